>>> rtl/eased_tween_interpolator_assert.svh
// Assertion macros for the eased tween interpolator
`ifndef EASED_TWEEN_INTERPOLATOR_ASSERT_SVH
`define EASED_TWEEN_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ETI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ETI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ETI_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ETI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/eti_pkg.sv
// Shared types and constants of the eased tween interpolator
`default_nettype none
package eti_pkg;

    localparam logic [1:0] CMD_SET     = 2'd0;
    localparam logic [1:0] CMD_RUN     = 2'd1;
    localparam logic [1:0] CMD_TOWARD  = 2'd2;
    localparam logic [1:0] CMD_ADVANCE = 2'd3;

    localparam logic [1:0] CURVE_LINEAR    = 2'd0;
    localparam logic [1:0] CURVE_CUBIC_OUT = 2'd1;
    localparam logic [1:0] CURVE_BACK_OUT  = 2'd2;

    localparam int VALUE_W = 16;
    localparam int TICK_W  = 32;
    localparam int SPAN_W  = 24;
    localparam int PROG_W  = 16;
    localparam int M_W     = PROG_W + 1;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int S_W     = 19;

    localparam int DIV_STEPS = PROG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [M_W-1:0]            Q16_ONE = 17'h10000;
    localparam logic signed [MUL_B_W-1:0] BACK_C  = 19'sd111515;
    localparam logic signed [MUL_B_W-1:0] BACK_C1 = 19'sd177051;
    localparam logic signed [MUL_P_W-1:0] ROUND_HALF = 53'sd32768;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DECODE,
        OP_DIV,
        OP_MUL_MM,
        OP_MUL_M2M,
        OP_MUL_A,
        OP_MUL_B,
        OP_SHAPE,
        OP_MUL_FIN,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        logic   latch_in;
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic adv_go;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/eti_datapath.sv
// Tween state, progress divider, shared multiplier and output register
`default_nettype none
module eti_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire eti_pkg::dp_cmd_t             cmd,
    output eti_pkg::dp_status_t               status,
    input  wire logic [1:0]                   in_command,
    input  wire logic signed [eti_pkg::VALUE_W-1:0] in_target,
    input  wire logic [eti_pkg::TICK_W-1:0]   in_timestamp,
    input  wire logic [eti_pkg::SPAN_W-1:0]   in_duration,
    input  wire logic [1:0]                   in_curve,
    output logic signed [eti_pkg::VALUE_W-1:0] out_value,
    output logic                              out_busy
);

    logic [1:0]                          cmd_reg;
    logic signed [eti_pkg::VALUE_W-1:0]  tv_reg;
    logic [eti_pkg::TICK_W-1:0]          ts_reg;
    logic [eti_pkg::SPAN_W-1:0]          dur_reg;
    logic [1:0]                          kind_in_reg;

    logic signed [eti_pkg::VALUE_W-1:0]  present_reg;
    logic signed [eti_pkg::VALUE_W-1:0]  origin_reg;
    logic signed [eti_pkg::VALUE_W-1:0]  goal_reg;
    logic [eti_pkg::TICK_W-1:0]          start_reg;
    logic [eti_pkg::SPAN_W-1:0]          span_reg;
    logic [1:0]                          curve_reg;
    logic                                running_reg;

    logic [eti_pkg::SPAN_W-1:0]          rem_reg;
    logic [eti_pkg::PROG_W-1:0]          quot_reg;
    logic [32:0]                         m2_reg;
    logic [32:0]                         m3s_reg;
    logic [16:0]                         a_reg;
    logic signed [eti_pkg::S_W-1:0]      s_reg;
    logic signed [eti_pkg::MUL_P_W-1:0]  mul_reg;

    logic signed [eti_pkg::VALUE_W-1:0]  out_value_reg;
    logic                                out_busy_reg;

    logic [eti_pkg::TICK_W-1:0]          elapsed;
    logic                                finish;
    logic                                same;
    logic [eti_pkg::SPAN_W:0]            div_shift;
    logic                                div_bit;
    logic [eti_pkg::M_W-1:0]             m_w;
    logic signed [16:0]                  delta;
    logic signed [eti_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [eti_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [eti_pkg::MUL_P_W-1:0]  mul_prod;
    logic signed [eti_pkg::S_W-1:0]      s_next;
    logic signed [eti_pkg::MUL_P_W-1:0]  rnd;
    logic signed [eti_pkg::MUL_P_W-1:0]  shifted;
    logic signed [20:0]                  v21;
    logic signed [eti_pkg::VALUE_W-1:0]  v_sat;

    assign elapsed   = ts_reg - start_reg;
    assign finish    = elapsed >= {8'b0, span_reg};
    assign same      = running_reg ? (goal_reg == tv_reg) : (present_reg == tv_reg);
    assign div_shift = {rem_reg, 1'b0};
    assign div_bit   = div_shift >= {1'b0, span_reg};
    assign m_w       = eti_pkg::Q16_ONE - {1'b0, quot_reg};
    assign delta     = {goal_reg[15], goal_reg} - {origin_reg[15], origin_reg};

    assign status.adv_go = (cmd_reg == eti_pkg::CMD_ADVANCE) && running_reg
                           && (span_reg != '0) && !finish;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            eti_pkg::OP_MUL_MM: begin
                mul_a = {17'b0, m_w};
                mul_b = {2'b0, m_w};
            end
            eti_pkg::OP_MUL_M2M: begin
                mul_a = {1'b0, mul_reg[32:0]};
                mul_b = {2'b0, m_w};
            end
            eti_pkg::OP_MUL_A: begin
                mul_a = {1'b0, m2_reg};
                mul_b = eti_pkg::BACK_C;
            end
            eti_pkg::OP_MUL_B: begin
                mul_a = {1'b0, m3s_reg};
                mul_b = eti_pkg::BACK_C1;
            end
            eti_pkg::OP_MUL_FIN: begin
                mul_a = {{17{delta[16]}}, delta};
                mul_b = s_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    always_comb begin
        case (curve_reg)
            eti_pkg::CURVE_CUBIC_OUT:
                s_next = 19'sh10000 - $signed({2'b0, m3s_reg[32:16]});
            eti_pkg::CURVE_BACK_OUT:
                s_next = 19'sh10000 + $signed({2'b0, a_reg})
                         - $signed({1'b0, mul_reg[49:32]});
            default:
                s_next = $signed({3'b0, quot_reg});
        endcase
    end

    assign rnd     = mul_reg + eti_pkg::ROUND_HALF;
    assign shifted = rnd >>> 16;
    assign v21     = $signed({{5{origin_reg[15]}}, origin_reg})
                     + $signed({shifted[19], shifted[19:0]});

    always_comb begin
        if (v21 > 21'sd32767) begin
            v_sat = 16'sh7FFF;
        end else if (v21 < -21'sd32768) begin
            v_sat = 16'sh8000;
        end else begin
            v_sat = v21[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg     <= in_command;
            tv_reg      <= in_target;
            ts_reg      <= in_timestamp;
            dur_reg     <= in_duration;
            kind_in_reg <= in_curve;
        end
        case (cmd.op)
            eti_pkg::OP_DECODE:  rem_reg <= elapsed[eti_pkg::SPAN_W-1:0];
            eti_pkg::OP_DIV: begin
                rem_reg  <= div_bit ? div_shift[eti_pkg::SPAN_W-1:0] - span_reg
                                    : div_shift[eti_pkg::SPAN_W-1:0];
                quot_reg <= {quot_reg[eti_pkg::PROG_W-2:0], div_bit};
            end
            eti_pkg::OP_MUL_M2M: m2_reg  <= mul_reg[32:0];
            eti_pkg::OP_MUL_A:   m3s_reg <= mul_reg[48:16];
            eti_pkg::OP_MUL_B:   a_reg   <= mul_reg[48:32];
            eti_pkg::OP_SHAPE:   s_reg   <= s_next;
            default: begin
            end
        endcase
        if (cmd.op == eti_pkg::OP_MUL_MM || cmd.op == eti_pkg::OP_MUL_M2M
            || cmd.op == eti_pkg::OP_MUL_A || cmd.op == eti_pkg::OP_MUL_B
            || cmd.op == eti_pkg::OP_MUL_FIN) begin
            mul_reg <= mul_prod;
        end
        if (cmd.load_out) begin
            out_value_reg <= present_reg;
            out_busy_reg  <= running_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            origin_reg  <= '0;
            goal_reg    <= '0;
            start_reg   <= '0;
            span_reg    <= '0;
            curve_reg   <= eti_pkg::CURVE_LINEAR;
            running_reg <= 1'b0;
        end else if (cmd.op == eti_pkg::OP_DECODE) begin
            case (cmd_reg)
                eti_pkg::CMD_SET: begin
                    present_reg <= tv_reg;
                    origin_reg  <= tv_reg;
                    goal_reg    <= tv_reg;
                    running_reg <= 1'b0;
                end
                eti_pkg::CMD_RUN, eti_pkg::CMD_TOWARD: begin
                    if (cmd_reg == eti_pkg::CMD_RUN || !same) begin
                        if (dur_reg == '0) begin
                            present_reg <= tv_reg;
                            origin_reg  <= tv_reg;
                            goal_reg    <= tv_reg;
                            running_reg <= 1'b0;
                        end else begin
                            origin_reg  <= present_reg;
                            goal_reg    <= tv_reg;
                            start_reg   <= ts_reg;
                            span_reg    <= dur_reg;
                            curve_reg   <= kind_in_reg;
                            running_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                    if (running_reg && span_reg != '0 && finish) begin
                        present_reg <= goal_reg;
                        running_reg <= 1'b0;
                    end
                end
            endcase
        end else if (cmd.op == eti_pkg::OP_COMMIT) begin
            present_reg <= v_sat;
        end
    end

    assign out_value = out_value_reg;
    assign out_busy  = out_busy_reg;

endmodule
`default_nettype wire

>>> rtl/eti_ctrl.sv
// Sequencer that steps the datapath through decode, divide, shape and commit
`default_nettype none
module eti_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire eti_pkg::dp_status_t status,
    output eti_pkg::dp_cmd_t         cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_DECODE = 11'b000_0000_0010,
        ST_DIV    = 11'b000_0000_0100,
        ST_MMM    = 11'b000_0000_1000,
        ST_M2M    = 11'b000_0001_0000,
        ST_MA     = 11'b000_0010_0000,
        ST_MB     = 11'b000_0100_0000,
        ST_SHAPE  = 11'b000_1000_0000,
        ST_MFIN   = 11'b001_0000_0000,
        ST_COMMIT = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [eti_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.latch_in = 1'b0;
        cmd.op       = eti_pkg::OP_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.latch_in = s_tvalid;
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.op     = eti_pkg::OP_DECODE;
                cnt_next   = '0;
                state_next = status.adv_go ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                cmd.op   = eti_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == eti_pkg::DIV_CNT_W'(eti_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_MMM;
                end
            end
            ST_MMM: begin
                cmd.op     = eti_pkg::OP_MUL_MM;
                state_next = ST_M2M;
            end
            ST_M2M: begin
                cmd.op     = eti_pkg::OP_MUL_M2M;
                state_next = ST_MA;
            end
            ST_MA: begin
                cmd.op     = eti_pkg::OP_MUL_A;
                state_next = ST_MB;
            end
            ST_MB: begin
                cmd.op     = eti_pkg::OP_MUL_B;
                state_next = ST_SHAPE;
            end
            ST_SHAPE: begin
                cmd.op     = eti_pkg::OP_SHAPE;
                state_next = ST_MFIN;
            end
            ST_MFIN: begin
                cmd.op     = eti_pkg::OP_MUL_FIN;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.op     = eti_pkg::OP_COMMIT;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/eased_tween_interpolator.sv
// Top level of the eased tween interpolator
//
//   channel  dir  tdata                          tuser
//   s_       in   target, timestamp, duration    command, curve_select
//   m_       out  current_value                  busy_res
//
// Set, run, toward and a finishing or idle advance go from accept through
// decode to the result. A mid-tween advance also runs the bit-serial progress
// divider for 16 quotient bits, then the shared 34x19 multiply and shape steps.
// Reset is synchronous; all tween state clears to zero, linear, idle.
// A new transaction is taken while the previous result waits on m_tready.
`default_nettype none
`include "eased_tween_interpolator_assert.svh"
module eased_tween_interpolator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] target_value, [47:16] timestamp, [71:48] duration
    input  wire logic [71:0] s_tdata,
    // [1:0] command, [3:2] curve_select
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] current_value
    output logic [15:0]      m_tdata,
    // [0] busy_res
    output logic [0:0]       m_tuser
);

    eti_pkg::dp_cmd_t    ctrl_cmd;
    eti_pkg::dp_status_t dp_status;
    logic signed [eti_pkg::VALUE_W-1:0] out_value;
    logic                out_busy;

    eti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    eti_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (ctrl_cmd),
        .status       (dp_status),
        .in_command   (s_tuser[1:0]),
        .in_target    (s_tdata[15:0]),
        .in_timestamp (s_tdata[47:16]),
        .in_duration  (s_tdata[71:48]),
        .in_curve     (s_tuser[3:2]),
        .out_value    (out_value),
        .out_busy     (out_busy)
    );

    assign m_tdata    = out_value;
    assign m_tuser[0] = out_busy;

    `ETI_ASSERT_NEXT(a_accept_decodes, aclk, aresetn, s_tvalid && s_tready, ctrl_cmd.op == eti_pkg::OP_DECODE)
    `ETI_ASSERT_SAME(a_load_when_free, aclk, aresetn, ctrl_cmd.load_out, !m_tvalid || m_tready)
    `ETI_ASSERT_NEXT(a_advance_divides, aclk, aresetn, ctrl_cmd.op == eti_pkg::OP_DECODE && dp_status.adv_go, ctrl_cmd.op == eti_pkg::OP_DIV)

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking stream testbench for the eased tween interpolator
`default_nettype none
module tb;

    localparam longint Q16_UNIT = 65536;
    localparam longint EASE_K   = 111515;
    localparam longint EASE_K1  = 177051;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int IDLE_PCT     = 9;
    localparam int QUIET_FROM   = 4000;
    localparam int QUIET_TO     = 9000;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] target;
        logic [31:0]        stamp;
        logic [23:0]        span;
        logic [1:0]         curve;
    } tween_cmd_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               busy;
    } tween_out_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    eased_tween_interpolator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    tween_cmd_t pending_q[$];
    tween_out_t want_q[$];
    tween_cmd_t held_cmd;

    logic signed [15:0] tw_present = '0;
    logic signed [15:0] tw_origin  = '0;
    logic signed [15:0] tw_goal    = '0;
    logic [31:0]        tw_start   = '0;
    logic [23:0]        tw_span    = '0;
    logic [1:0]         tw_curve   = eti_pkg::CURVE_LINEAR;
    logic               tw_running = 1'b0;

    int cycle_count  = 0;
    int n_in         = 0;
    int n_results    = 0;
    int n_mid        = 0;
    int n_finished   = 0;
    int n_saturated  = 0;
    int n_mismatch   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    logic signed [15:0] gen_goal = '0;

    function automatic longint ease_q16(logic [1:0] curve, longint p);
        longint m, m2, m3;
        m  = Q16_UNIT - p;
        m2 = m * m;
        m3 = m2 * m;
        case (curve)
            eti_pkg::CURVE_CUBIC_OUT: return Q16_UNIT - (m3 >>> 32);
            eti_pkg::CURVE_BACK_OUT:  return Q16_UNIT + ((EASE_K * m2) >>> 32)
                                            - ((EASE_K1 * (m3 >>> 16)) >>> 32);
            default:                  return p;
        endcase
    endfunction

    function automatic void jump_to(logic signed [15:0] v);
        tw_present = v;
        tw_origin  = v;
        tw_goal    = v;
        tw_running = 1'b0;
    endfunction

    function automatic void start_tween(tween_cmd_t c);
        if (c.span == '0) begin
            jump_to(c.target);
        end else begin
            tw_origin  = tw_present;
            tw_goal    = c.target;
            tw_start   = c.stamp;
            tw_span    = c.span;
            tw_curve   = c.curve;
            tw_running = 1'b1;
        end
    endfunction

    function automatic tween_out_t predict_tween(tween_cmd_t c);
        tween_out_t r;
        logic [31:0] elapsed;
        longint unsigned p;
        longint s, delta, v;
        case (c.cmd)
            eti_pkg::CMD_SET: jump_to(c.target);
            eti_pkg::CMD_RUN: start_tween(c);
            eti_pkg::CMD_TOWARD: begin
                if (tw_running ? (tw_goal != c.target) : (tw_present != c.target))
                    start_tween(c);
            end
            default: begin
                if (tw_running && tw_span != '0) begin
                    elapsed = c.stamp - tw_start;
                    p = ({32'd0, elapsed} << 16) / {40'd0, tw_span};
                    if (p >= 64'(Q16_UNIT)) begin
                        tw_present = tw_goal;
                        tw_running = 1'b0;
                        n_finished++;
                    end else begin
                        s = ease_q16(tw_curve, longint'(p));
                        delta = longint'(tw_goal) - longint'(tw_origin);
                        v = longint'(tw_origin) + ((delta * s + 32768) >>> 16);
                        if (v > 32767 || v < -32768)
                            n_saturated++;
                        if (v > 32767)
                            v = 32767;
                        if (v < -32768)
                            v = -32768;
                        tw_present = 16'(v);
                        n_mid++;
                    end
                end
            end
        endcase
        r.value = tw_present;
        r.busy  = tw_running;
        return r;
    endfunction

    task automatic add_item(logic [1:0] cmd, logic [15:0] target, logic [31:0] stamp,
                            logic [23:0] span, logic [1:0] curve);
        tween_cmd_t c;
        c.cmd    = cmd;
        c.target = target;
        c.stamp  = stamp;
        c.span   = span;
        c.curve  = curve;
        pending_q.push_back(c);
        if (cmd != eti_pkg::CMD_ADVANCE)
            gen_goal = target;
    endtask

    task automatic add_advance(logic [31:0] stamp);
        add_item(eti_pkg::CMD_ADVANCE, 16'($urandom), stamp, 24'($urandom), 2'($urandom));
    endtask

    task automatic gen_tween_burst();
        logic [31:0] base;
        logic [23:0] dur;
        logic [15:0] tgt;
        logic [1:0]  op;
        longint unsigned off;
        int r, n;
        r = $urandom_range(0, 99);
        if (r < 3)
            dur = '0;
        else if (r < 50)
            dur = 24'($urandom_range(1, 64));
        else if (r < 85)
            dur = 24'($urandom_range(65, 4000));
        else if (r < 95)
            dur = 24'($urandom_range(4001, 1000000));
        else
            dur = 24'($urandom_range(1000001, 24'hFFFFFF));
        base = $urandom;
        if ($urandom_range(0, 3) == 0)
            add_item(eti_pkg::CMD_SET, 16'($urandom), $urandom, 24'($urandom), 2'($urandom));
        r = $urandom_range(0, 9);
        if (r < 2)
            tgt = gen_goal;
        else if (r == 2)
            tgt = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else
            tgt = 16'($urandom);
        op = $urandom_range(0, 1) ? eti_pkg::CMD_RUN : eti_pkg::CMD_TOWARD;
        add_item(op, tgt, base, dur, 2'($urandom));
        n = $urandom_range(1, 8);
        off = 0;
        for (int i = 0; i < n; i++) begin
            off = off + (longint'(dur) * $urandom_range(0, 400)) / 1000;
            if ($urandom_range(0, 9) == 0)
                add_item($urandom_range(0, 1) ? eti_pkg::CMD_RUN : eti_pkg::CMD_TOWARD,
                         $urandom_range(0, 1) ? gen_goal : 16'($urandom),
                         base + 32'(off), dur, 2'($urandom));
            else
                add_advance(base + 32'(off));
        end
    endtask

    task automatic report_mismatch(string what, tween_out_t want, tween_out_t got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch %0d at cycle %0d: %s, want value %0d busy %0b, %s %0d busy %0b",
                     n_mismatch, cycle_count, what, want.value, want.busy,
                     "got value", got.value, got.busy);
    endtask

    // driver
    always @(posedge aclk) begin : drive_input
        bit taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            taken = s_tvalid && s_tready;
            if (taken) begin
                want_q.push_back(predict_tween(held_cmd));
                n_in++;
            end
            if (!s_tvalid || taken) begin
                if (pending_q.size() > 0 &&
                    ((cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    held_cmd = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {held_cmd.span, held_cmd.stamp, held_cmd.target};
                    s_tuser  <= {held_cmd.curve, held_cmd.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) ||
                        ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor
    always @(posedge aclk) begin : check_output
        tween_out_t got;
        tween_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata;
            got.busy  = m_tuser[0];
            n_results++;
            if (want_q.size() == 0) begin
                want = '0;
                report_mismatch("result with nothing outstanding", want, got);
            end else begin
                want = want_q.pop_front();
                if (got.value !== want.value || got.busy !== want.busy)
                    report_mismatch("wrong result", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, want_q.size());
            $display("eased_tween_interpolator regression: fail");
            $finish;
        end
    end

    initial begin
        // directed: extremes, every command, idle and zero-time cases
        add_advance(32'd0);
        add_item(eti_pkg::CMD_SET, 16'h7FFF, 32'hFFFFFFFF, 24'hFFFFFF, eti_pkg::CURVE_BACK_OUT);
        add_item(eti_pkg::CMD_SET, 16'h8000, 32'd0, 24'd0, eti_pkg::CURVE_LINEAR);
        add_item(eti_pkg::CMD_RUN, 16'h7FFF, 32'd5, 24'd0, eti_pkg::CURVE_CUBIC_OUT);
        add_item(eti_pkg::CMD_TOWARD, 16'h7FFF, 32'd9, 24'd50, eti_pkg::CURVE_LINEAR);
        add_item(eti_pkg::CMD_SET, 16'h8000, 32'd0, 24'd0, eti_pkg::CURVE_LINEAR);
        add_item(eti_pkg::CMD_RUN, 16'h7FFF, 32'd100, 24'd1000, eti_pkg::CURVE_BACK_OUT);
        add_advance(32'd100);
        add_advance(32'd300);
        add_item(eti_pkg::CMD_TOWARD, 16'h7FFF, 32'd320, 24'd9, eti_pkg::CURVE_LINEAR);
        add_advance(32'd700);
        add_advance(32'd1100);
        add_advance(32'd1200);
        add_item(eti_pkg::CMD_RUN, 16'h8000, 32'hFFFFFF00, 24'hFFFFFF, eti_pkg::CURVE_BACK_OUT);
        add_advance(32'h00000100);
        add_advance(32'h00FFFE00);
        add_item(eti_pkg::CMD_TOWARD, 16'h0100, 32'h00FFFF00, 24'd7, eti_pkg::CURVE_CUBIC_OUT);
        add_advance(32'h00FFFF02);
        add_advance(32'h00FFFF06);
        add_item(eti_pkg::CMD_RUN, 16'h4000, 32'h12345678, 24'd1, 2'd3);
        add_advance(32'h12345678);
        add_advance(32'h12345679);
        add_item(eti_pkg::CMD_RUN, 16'hC000, 32'hFFFFFFF0, 24'd64, eti_pkg::CURVE_LINEAR);
        add_advance(32'h00000010);
        add_advance(32'h7FFFFFFF);

        while (pending_q.size() < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 99) < 75)
                gen_tween_burst();
            else
                add_item(2'($urandom), 16'($urandom), $urandom, 24'($urandom), 2'($urandom));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() > 0 || s_tvalid || want_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d transactions in, %0d results checked over %0d cycles",
                 n_in, n_results, cycle_count);
        $display("%0d mid-tween advances (%0d saturated), %0d tweens run to their end",
                 n_mid, n_saturated, n_finished);
        if (n_mismatch == 0 && want_q.size() == 0) begin
            $display("eased_tween_interpolator regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, want_q.size());
            $display("eased_tween_interpolator regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/eti_pkg.sv
rtl/eti_datapath.sv
rtl/eti_ctrl.sv
rtl/eased_tween_interpolator.sv
tb/sv/tb.sv
